// ===== rtl/core/pal_pkg.sv =====
// shared types and constants of the preferential attachment linker
`default_nettype none

package pal_pkg;

  // field widths
  localparam int FRAC_W = 16;
  localparam int NODE_W = 11;
  localparam int IDX_W  = 10;
  localparam int DEG_W  = 10;
  localparam int SUM_W  = 11;
  localparam int STAT_W = 2;
  localparam int PROD_W = FRAC_W + SUM_W;

  // largest table that a node index can address
  localparam int TABLE_MAX = 1024;

  // reset value of the node count register
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1024);

  // first edge: nodes 0 and 1 with degree one each
  localparam logic [NODE_W-1:0] FIRST_NEXT = NODE_W'(2);
  localparam logic [SUM_W-1:0]  FIRST_SUM  = SUM_W'(2);

  // item kinds
  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ADDED     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_RESTARTED = 2'd2;

  // degree table write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT0,
    WR_INIT1,
    WR_PICK,
    WR_FRESH
  } wr_sel_t;

  // which result to load into the output register
  typedef enum logic [1:0] {
    RES_ADD,
    RES_FULL,
    RES_RESTART
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     init;
    logic     mul;
    logic     walk;
    logic     grow;
    wr_sel_t  wr_sel;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_restart;
    logic full;
    logic hit;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/pal_in_if.sv =====
// input item channel: valid, ready and the item fields
`default_nettype none

interface pal_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [pal_pkg::FRAC_W-1:0] random_fraction;

  modport source (output valid, kind, random_fraction, input ready);
  modport sink (input valid, kind, random_fraction, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pal_out_if.sv =====
// result item channel: valid, ready and the result fields
`default_nettype none

interface pal_out_if;
  logic                       valid;
  logic                       ready;
  logic [pal_pkg::IDX_W-1:0]  new_node;
  logic [pal_pkg::IDX_W-1:0]  partner_node;
  logic [pal_pkg::DEG_W-1:0]  partner_degree;
  logic [pal_pkg::SUM_W-1:0]  total_degree;
  logic [pal_pkg::STAT_W-1:0] status;

  modport source (output valid, new_node, partner_node, partner_degree, total_degree, status,
                  input ready);
  modport sink (input valid, new_node, partner_node, partner_degree, total_degree, status,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pal_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module pal_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/pal_ctrl.sv =====
// controller state machine of the linker
`default_nettype none

module pal_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  output      logic          out_valid,
  input  wire logic          out_ready,
  input  wire pal_pkg::sts_t sts,
  output      pal_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_BOOT0,
    S_BOOT1,
    S_IDLE,
    S_CHECK,
    S_CLR0,
    S_CLR1,
    S_MUL,
    S_WALK,
    S_WR_PICK,
    S_WR_FRESH,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  pal_pkg::res_sel_t res_sel_r, res_sel_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state, commands and result handshake
  always_comb begin
    state_nxt     = state_r;
    res_sel_nxt   = res_sel_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    cmd          = '0;
    cmd.wr_sel   = pal_pkg::WR_NONE;
    cmd.res_sel  = res_sel_r;
    unique case (state_r)
      S_BOOT0: begin
        cmd.init   = 1'b1;
        cmd.wr_sel = pal_pkg::WR_INIT0;
        state_nxt  = S_BOOT1;
      end
      S_BOOT1: begin
        cmd.wr_sel = pal_pkg::WR_INIT1;
        state_nxt  = S_IDLE;
      end
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_restart) begin
          res_sel_nxt = pal_pkg::RES_RESTART;
          state_nxt   = S_CLR0;
        end else if (sts.full) begin
          res_sel_nxt = pal_pkg::RES_FULL;
          state_nxt   = S_DONE;
        end else begin
          res_sel_nxt = pal_pkg::RES_ADD;
          state_nxt   = S_MUL;
        end
      end
      S_CLR0: begin
        cmd.init   = 1'b1;
        cmd.wr_sel = pal_pkg::WR_INIT0;
        state_nxt  = S_CLR1;
      end
      S_CLR1: begin
        cmd.wr_sel = pal_pkg::WR_INIT1;
        state_nxt  = S_DONE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.hit) begin
          state_nxt = S_WR_PICK;
        end
      end
      S_WR_PICK: begin
        cmd.wr_sel = pal_pkg::WR_PICK;
        state_nxt  = S_WR_FRESH;
      end
      S_WR_FRESH: begin
        cmd.wr_sel = pal_pkg::WR_FRESH;
        cmd.grow   = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT0;
      out_valid_r <= 1'b0;
      res_sel_r   <= pal_pkg::RES_ADD;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      res_sel_r   <= res_sel_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pal_dp.sv =====
// datapath: degree table, running-sum walk, counters and result register
`default_nettype none

module pal_dp #(
  parameter int DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [pal_pkg::NODE_W-1:0]   cfg_wdata,
  input  wire logic                         in_kind,
  input  wire logic [pal_pkg::FRAC_W-1:0]   in_frac,
  input  wire pal_pkg::cmd_t                cmd,
  output      pal_pkg::sts_t                sts,
  output      logic [pal_pkg::IDX_W-1:0]    new_node_r,
  output      logic [pal_pkg::IDX_W-1:0]    partner_node_r,
  output      logic [pal_pkg::DEG_W-1:0]    partner_degree_r,
  output      logic [pal_pkg::SUM_W-1:0]    total_degree_r,
  output      logic [pal_pkg::STAT_W-1:0]   status_r
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [pal_pkg::NODE_W-1:0] DEPTH_N = pal_pkg::NODE_W'(DEPTH);
  localparam logic [pal_pkg::NODE_W-1:0] MIN_N   = pal_pkg::NODE_W'(2);

  logic [pal_pkg::NODE_W-1:0] node_count_r;
  logic [pal_pkg::SUM_W-1:0]  sum_r;
  logic [pal_pkg::NODE_W-1:0] next_node_r;
  logic                       kind_r;
  logic [pal_pkg::FRAC_W-1:0] frac_r;
  logic [pal_pkg::PROD_W-1:0] target_r;
  logic [pal_pkg::NODE_W-1:0] rd_idx_r;
  logic [pal_pkg::NODE_W-1:0] chk_idx_r;
  logic                       chk_vld_r;
  logic [pal_pkg::SUM_W-1:0]  cum_r;
  logic [pal_pkg::IDX_W-1:0]  pick_r;
  logic [pal_pkg::DEG_W-1:0]  pick_deg_r;

  logic [pal_pkg::DEG_W-1:0]  rdata;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [pal_pkg::DEG_W-1:0]  wdata;

  logic [pal_pkg::NODE_W-1:0] lim_cap;
  logic [pal_pkg::NODE_W-1:0] limit;
  logic [pal_pkg::NODE_W-1:0] last_idx;
  logic [pal_pkg::SUM_W-1:0]  cum_sum;
  logic                       below;

  // degree table
  pal_ram #(
    .WIDTH (pal_pkg::DEG_W),
    .DEPTH (DEPTH)
  ) u_deg_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (rd_idx_r[AW-1:0]),
    .rdata_r (rdata)
  );

  // table write source
  always_comb begin
    we    = 1'b1;
    waddr = '0;
    wdata = pal_pkg::DEG_W'(1);
    unique case (cmd.wr_sel)
      pal_pkg::WR_INIT0: begin
        waddr = AW'(0);
      end
      pal_pkg::WR_INIT1: begin
        waddr = AW'(1);
      end
      pal_pkg::WR_PICK: begin
        waddr = pick_r[AW-1:0];
        wdata = pick_deg_r;
      end
      pal_pkg::WR_FRESH: begin
        waddr = next_node_r[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // effective node limit and full check
  assign lim_cap  = (node_count_r > DEPTH_N) ? DEPTH_N : node_count_r;
  assign limit    = (lim_cap < MIN_N) ? MIN_N : lim_cap;
  assign last_idx = next_node_r - pal_pkg::NODE_W'(1);

  // one step of the running-sum walk
  assign cum_sum = cum_r + pal_pkg::SUM_W'(rdata);
  assign below   = (target_r <= {cum_sum, {pal_pkg::FRAC_W{1'b0}}});

  assign sts.is_restart = (kind_r == pal_pkg::KIND_RESTART);
  assign sts.full       = (next_node_r >= limit);
  assign sts.hit        = chk_vld_r && (below || (chk_idx_r == last_idx));

  // control registers: node count, graph size, walk pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= pal_pkg::NODE_COUNT_RST;
      sum_r        <= pal_pkg::FIRST_SUM;
      next_node_r  <= pal_pkg::FIRST_NEXT;
      chk_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (cmd.init) begin
        sum_r       <= pal_pkg::FIRST_SUM;
        next_node_r <= pal_pkg::FIRST_NEXT;
      end else if (cmd.grow) begin
        sum_r       <= sum_r + pal_pkg::SUM_W'(2);
        next_node_r <= next_node_r + pal_pkg::NODE_W'(1);
      end
      chk_vld_r <= cmd.walk;
    end
  end

  // item capture, target product and walk
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      frac_r <= in_frac;
    end
    if (cmd.mul) begin
      target_r <= pal_pkg::PROD_W'(frac_r) * pal_pkg::PROD_W'(sum_r);
      rd_idx_r <= '0;
      cum_r    <= '0;
    end else if (cmd.walk) begin
      rd_idx_r <= rd_idx_r + pal_pkg::NODE_W'(1);
      if (chk_vld_r) begin
        cum_r <= cum_sum;
      end
    end
    chk_idx_r <= rd_idx_r;
    if (cmd.walk && sts.hit) begin
      pick_r     <= chk_idx_r[pal_pkg::IDX_W-1:0];
      pick_deg_r <= rdata + pal_pkg::DEG_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        pal_pkg::RES_ADD: begin
          new_node_r       <= last_idx[pal_pkg::IDX_W-1:0];
          partner_node_r   <= pick_r;
          partner_degree_r <= pick_deg_r;
          total_degree_r   <= sum_r;
          status_r         <= pal_pkg::ST_ADDED;
        end
        pal_pkg::RES_RESTART: begin
          new_node_r       <= pal_pkg::IDX_W'(1);
          partner_node_r   <= '0;
          partner_degree_r <= pal_pkg::DEG_W'(1);
          total_degree_r   <= pal_pkg::FIRST_SUM;
          status_r         <= pal_pkg::ST_RESTARTED;
        end
        default: begin
          new_node_r       <= '0;
          partner_node_r   <= '0;
          partner_degree_r <= '0;
          total_degree_r   <= sum_r;
          status_r         <= pal_pkg::ST_FULL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/preferential_attachment_linker_core.sv =====
// top level of the preferential attachment linker
// flow: check, target product, table walk, partner and new node writes for an add item;
//   a full graph goes from the check to the result, a restart rewrites the first edge
// throughput: one item at a time; an add item is bound by the walk over the degree table,
//   one entry per cycle through the table ram's single read port
// reset: node_count returns to 1024 and the first edge is written into the table in the
//   boot states S_BOOT0 and S_BOOT1 after reset, during which no item is accepted
`default_nettype none

module preferential_attachment_linker_core #(
  parameter int MAX_NODES = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  pal_in_if.sink                          in_ch,
  pal_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [pal_pkg::NODE_W-1:0] cfg_wdata
);

  localparam int DEPTH = (MAX_NODES > pal_pkg::TABLE_MAX) ? pal_pkg::TABLE_MAX : MAX_NODES;

  pal_pkg::cmd_t cmd;
  pal_pkg::sts_t sts;

  // controller
  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  pal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (in_ch.kind),
    .in_frac          (in_ch.random_fraction),
    .cmd              (cmd),
    .sts              (sts),
    .new_node_r       (out_ch.new_node),
    .partner_node_r   (out_ch.partner_node),
    .partner_degree_r (out_ch.partner_degree),
    .total_degree_r   (out_ch.total_degree),
    .status_r         (out_ch.status)
  );

  // one item in flight: no second accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while another is in work");

  // an added edge always points back to an older node
  a_partner_older: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == pal_pkg::ST_ADDED)) |->
      (out_ch.partner_node < out_ch.new_node))
    else $error("partner node is not older than the new node");

  // every edge adds two to the total, so it stays even
  a_total_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !out_ch.total_degree[0])
    else $error("total degree is odd");

endmodule

`default_nettype wire
